[rtl/generational_handle_table_top_assert.svh]
// ----------------------------------------------------------------------------
// Generational handle table - assertion macros
// Concurrent assertion wrappers, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef GENERATIONAL_HANDLE_TABLE_TOP_ASSERT_SVH
`define GENERATIONAL_HANDLE_TABLE_TOP_ASSERT_SVH
`ifndef SYNTH
`define GHT_ASSERT_NOW(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("generational handle table assertion failed");
`define GHT_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("generational handle table assertion failed");
`else
`define GHT_ASSERT_NOW(name, clk, rst, ante, cons)
`define GHT_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif
`endif

[rtl/ght_pkg.sv]
// ----------------------------------------------------------------------------
// Generational handle table - package
// Widths, codes, shared types and helper functions.
// ----------------------------------------------------------------------------
`default_nettype none

package ght_pkg;

   localparam int SLOTS     = 64;
   localparam int IDX_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W     = $clog2(SLOTS + 1);
   localparam int SLOT_BITS = 16;
   localparam int ID_W      = 64;
   localparam int GEN_W     = 32;
   localparam int CAP_W     = 48;
   localparam int HANDLE_W  = 64;
   localparam int HGEN_W    = HANDLE_W - SLOT_BITS;
   localparam int STATUS_W  = 3;
   localparam int ICON_W    = 3;
   localparam int SICON_W   = 2;
   localparam int KIND_W    = 2;
   localparam int OKIND_W   = 2;
   localparam int USED_W    = 16;
   localparam int BOOT_W    = 64;
   localparam int ADDR_W    = 4;
   localparam int REG_LSB   = 3;

   localparam logic [ADDR_W-REG_LSB-1:0] REG_BOOT = '0;

   localparam logic [KIND_W-1:0] KIND_REGISTER     = 2'd0;
   localparam logic [KIND_W-1:0] KIND_RESOLVE_ICON = 2'd1;
   localparam logic [KIND_W-1:0] KIND_RESOLVE_ID   = 2'd2;
   localparam logic [KIND_W-1:0] KIND_FIND         = 2'd3;

   localparam logic [STATUS_W-1:0] STATUS_OK         = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_INVALID    = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_EXISTS     = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_NO_SPACE   = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_BAD_HANDLE = 3'd4;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND  = 3'd5;

   localparam logic [ICON_W-1:0] ICON_GENERIC   = 3'd0;
   localparam logic [ICON_W-1:0] ICON_MAX_VALID = 3'd3;
   localparam logic [ICON_W-1:0] ICON_FOLDER    = 3'd4;

   localparam logic [OKIND_W-1:0] OBJ_FILE = 2'd0;
   localparam logic [OKIND_W-1:0] OBJ_DIR  = 2'd1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic                valid;
      logic [ID_W-1:0]     identity;
      logic [GEN_W-1:0]    generation;
      logic [SICON_W-1:0]  icon;
   } slot_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [CAP_W-1:0]    handle_out;
      logic [ICON_W-1:0]   icon_out;
      logic [ID_W-1:0]     identity_out;
      logic [USED_W-1:0]   entries_used;
   } rsp_type;

   typedef struct packed {
      logic             shift;
      logic             wr_en;
      logic [IDX_W-1:0] wr_index;
      slot_type         wr_slot;
   } cell_ctrl_type;

   typedef struct packed {
      logic             busy;
      logic [CNT_W-1:0] used;
   } ctrl_status_type;

   function automatic logic [GEN_W-1:0] seed_of(input logic [BOOT_W-1:0] boot);
      logic [GEN_W-1:0] g;
      g = boot[GEN_W-1:0] ^ boot[BOOT_W-1:GEN_W];
      return (g == '0) ? GEN_W'(1) : g;
   endfunction

   function automatic logic [CAP_W-1:0] cap_of(input logic [IDX_W-1:0] idx,
                                               input logic [GEN_W-1:0] gen);
      return {gen, SLOT_BITS'(idx) + SLOT_BITS'(1)};
   endfunction

endpackage

`default_nettype wire

[rtl/ght_req_if.sv]
// ----------------------------------------------------------------------------
// Generational handle table - request channel
// Valid/ready channel carrying one table operation.
// ----------------------------------------------------------------------------
`default_nettype none

interface ght_req_if;
   import ght_pkg::*;

   logic                valid;
   logic                ready;
   logic [KIND_W-1:0]   kind;
   logic [ID_W-1:0]     type_identity;
   logic [ICON_W-1:0]   icon_in;
   logic [HANDLE_W-1:0] handle;
   logic [OKIND_W-1:0]  node_kind;

   modport source (output valid, kind, type_identity, icon_in, handle, node_kind,
                   input ready);
   modport sink   (input valid, kind, type_identity, icon_in, handle, node_kind,
                   output ready);
endinterface

`default_nettype wire

[rtl/ght_rsp_if.sv]
// ----------------------------------------------------------------------------
// Generational handle table - response channel
// Valid/ready channel carrying one operation result.
// ----------------------------------------------------------------------------
`default_nettype none

interface ght_rsp_if;
   import ght_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [CAP_W-1:0]    handle_out;
   logic [ICON_W-1:0]   icon_out;
   logic [ID_W-1:0]     identity_out;
   logic [USED_W-1:0]   entries_used;

   modport source (output valid, status, handle_out, icon_out, identity_out, entries_used,
                   input ready);
   modport sink   (input valid, status, handle_out, icon_out, identity_out, entries_used,
                   output ready);
endinterface

`default_nettype wire

[rtl/ght_cell.sv]
// ----------------------------------------------------------------------------
// Generational handle table - slot cell
// One table slot; rotates to its neighbour during a scan, loads on write, empties on clear.
// ----------------------------------------------------------------------------
`default_nettype none

module ght_cell (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            shift,
   input  wire logic            clear,
   input  wire logic            wr_sel,
   input  wire ght_pkg::slot_type wr_slot,
   input  wire ght_pkg::slot_type from_next,
   output ght_pkg::slot_type    q
);
   import ght_pkg::*;

   logic               valid_ff, valid_in;
   logic [ID_W-1:0]    identity_ff, identity_in;
   logic [GEN_W-1:0]   generation_ff, generation_in;
   logic [SICON_W-1:0] icon_ff, icon_in;

   always_comb begin
      valid_in      = valid_ff;
      identity_in   = identity_ff;
      generation_in = generation_ff;
      icon_in       = icon_ff;
      if (clear) begin
         valid_in = 1'b0;
      end else if (wr_sel) begin
         valid_in      = 1'b1;
         identity_in   = wr_slot.identity;
         generation_in = wr_slot.generation;
         icon_in       = wr_slot.icon;
      end else if (shift) begin
         valid_in      = from_next.valid;
         identity_in   = from_next.identity;
         generation_in = from_next.generation;
         icon_in       = from_next.icon;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      identity_ff   <= identity_in;
      generation_ff <= generation_in;
      icon_ff       <= icon_in;
   end

   assign q = '{valid: valid_ff, identity: identity_ff, generation: generation_ff,
                icon: icon_ff};

endmodule

`default_nettype wire

[rtl/ght_ctrl.sv]
// ----------------------------------------------------------------------------
// Generational handle table - sequencer
// Latches a request, compares the head cell while the ring rotates once,
// then forms the result and performs any slot fill.
// ----------------------------------------------------------------------------
`default_nettype none

module ght_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   ght_req_if.sink                      req_bus,
   ght_rsp_if.source                    rsp_bus,
   input  wire logic [ght_pkg::BOOT_W-1:0] boot,
   input  wire logic                    cfg_wr,
   input  wire ght_pkg::slot_type       head,
   output ght_pkg::cell_ctrl_type       cell_ctrl,
   output ght_pkg::ctrl_status_type     status_out
);
   import ght_pkg::*;

   state_type           state_ff, state_in;
   logic [IDX_W-1:0]    cnt_ff, cnt_in;
   logic [KIND_W-1:0]   kind_ff, kind_in;
   logic [ID_W-1:0]     id_ff, id_in;
   logic [ICON_W-1:0]   icon_ff, icon_in;
   logic [HANDLE_W-1:0] handle_ff, handle_in;
   logic [OKIND_W-1:0]  okind_ff, okind_in;
   logic                hit_ff, hit_in;
   logic [IDX_W-1:0]    hit_idx_ff, hit_idx_in;
   slot_type            hit_slot_ff, hit_slot_in;
   logic [CNT_W-1:0]    used_ff, used_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;

   logic                by_id, id_match, h_match, match;
   logic                full, do_write;
   logic [GEN_W-1:0]    gen_raw, new_gen;
   logic [CNT_W-1:0]    used_after;
   rsp_type             res;

   assign by_id    = (kind_ff == KIND_REGISTER) || (kind_ff == KIND_FIND);
   assign id_match = head.valid && (head.identity == id_ff);
   assign h_match  = head.valid
                     && (handle_ff[SLOT_BITS-1:0] == SLOT_BITS'(cnt_ff) + SLOT_BITS'(1))
                     && (handle_ff[HANDLE_W-1:SLOT_BITS] == HGEN_W'(head.generation));
   assign match    = by_id ? id_match : h_match;

   assign full    = (used_ff == CNT_W'(SLOTS));
   assign gen_raw = seed_of(boot) + GEN_W'(used_ff);
   assign new_gen = (gen_raw == '0) ? GEN_W'(1) : gen_raw;

   // result of the finished scan
   always_comb begin
      res          = '0;
      res.status   = STATUS_OK;
      do_write     = 1'b0;
      if (boot == '0) begin
         res.status = STATUS_INVALID;
      end else begin
         case (kind_ff)
            KIND_REGISTER: begin
               if (id_ff == '0 || icon_ff > ICON_MAX_VALID) begin
                  res.status = STATUS_INVALID;
               end else if (hit_ff) begin
                  if ({1'b0, hit_slot_ff.icon} != icon_ff) begin
                     res.status = STATUS_EXISTS;
                  end else begin
                     res.handle_out = cap_of(hit_idx_ff, hit_slot_ff.generation);
                  end
               end else if (full) begin
                  res.status = STATUS_NO_SPACE;
               end else begin
                  do_write       = 1'b1;
                  res.handle_out = cap_of(used_ff[IDX_W-1:0], new_gen);
               end
            end
            KIND_RESOLVE_ICON: begin
               if (okind_ff == OBJ_DIR) begin
                  res.icon_out = ICON_FOLDER;
               end else if (okind_ff != OBJ_FILE) begin
                  res.status = STATUS_INVALID;
               end else if (hit_ff) begin
                  res.icon_out = {1'b0, hit_slot_ff.icon};
               end else begin
                  res.icon_out = ICON_GENERIC;
               end
            end
            KIND_RESOLVE_ID: begin
               if (hit_ff) begin
                  res.identity_out = hit_slot_ff.identity;
               end else begin
                  res.status = STATUS_BAD_HANDLE;
               end
            end
            KIND_FIND: begin
               if (id_ff == '0) begin
                  res.status = STATUS_INVALID;
               end else if (hit_ff) begin
                  res.handle_out = cap_of(hit_idx_ff, hit_slot_ff.generation);
               end else begin
                  res.status = STATUS_NOT_FOUND;
               end
            end
            default: begin
               res.status = STATUS_INVALID;
            end
         endcase
      end
      used_after       = do_write ? CNT_W'(used_ff + CNT_W'(1)) : used_ff;
      res.entries_used = USED_W'(used_after);
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      kind_in      = kind_ff;
      id_in        = id_ff;
      icon_in      = icon_ff;
      handle_in    = handle_ff;
      okind_in     = okind_ff;
      hit_in       = hit_ff;
      hit_idx_in   = hit_idx_ff;
      hit_slot_in  = hit_slot_ff;
      used_in      = used_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;

      cell_ctrl.shift    = 1'b0;
      cell_ctrl.wr_en    = 1'b0;
      cell_ctrl.wr_index = used_ff[IDX_W-1:0];
      cell_ctrl.wr_slot  = '{valid: 1'b1, identity: id_ff, generation: new_gen,
                             icon: icon_ff[SICON_W-1:0]};

      req_bus.ready = (state_ff == ST_IDLE);

      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_bus.valid) begin
               kind_in   = req_bus.kind;
               id_in     = req_bus.type_identity;
               icon_in   = req_bus.icon_in;
               handle_in = req_bus.handle;
               okind_in  = req_bus.node_kind;
               cnt_in    = '0;
               hit_in    = 1'b0;
               state_in  = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cell_ctrl.shift = 1'b1;
            if (match && !hit_ff) begin
               hit_in      = 1'b1;
               hit_idx_in  = cnt_ff;
               hit_slot_in = head;
            end
            cnt_in = IDX_W'(cnt_ff + IDX_W'(1));
            if (cnt_ff == IDX_W'(SLOTS - 1)) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in    = 1'b1;
               rsp_in          = res;
               cell_ctrl.wr_en = do_write;
               used_in         = used_after;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (cfg_wr) begin
         used_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff      <= cnt_in;
      kind_ff     <= kind_in;
      id_ff       <= id_in;
      icon_ff     <= icon_in;
      handle_ff   <= handle_in;
      okind_ff    <= okind_in;
      hit_ff      <= hit_in;
      hit_idx_ff  <= hit_idx_in;
      hit_slot_ff <= hit_slot_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.status       = rsp_ff.status;
   assign rsp_bus.handle_out   = rsp_ff.handle_out;
   assign rsp_bus.icon_out     = rsp_ff.icon_out;
   assign rsp_bus.identity_out = rsp_ff.identity_out;
   assign rsp_bus.entries_used = rsp_ff.entries_used;

   assign status_out.busy = (state_ff != ST_IDLE);
   assign status_out.used = used_ff;

endmodule

`default_nettype wire

[rtl/generational_handle_table_top.sv]
// ----------------------------------------------------------------------------
// Generational handle table - top level
// Slot ring, sequencer and boot identity register.
// ----------------------------------------------------------------------------
// Every operation scans the whole table: the slots sit in a ring of cells that
// rotates once past a single compare point at the head, one slot per cycle,
// followed by a finish state that forms the result and performs any slot fill,
// waiting there while an earlier result is still held. A new request is taken
// only once the last result is loaded, in the cycle after, even while that
// result still waits in the output register. Slots fill in order and are never
// freed, so a new identity always goes to the slot given by the occupancy
// count. Writing the boot identity drops every slot at once; there is no
// clearing pass.
`default_nettype none

`include "generational_handle_table_top_assert.svh"

module generational_handle_table_top (
   input  wire logic                          clock,
   input  wire logic                          reset,
   ght_req_if.sink                            req_bus,
   ght_rsp_if.source                          rsp_bus,
   input  wire logic                          csr_psel,
   input  wire logic                          csr_penable,
   input  wire logic                          csr_pwrite,
   input  wire logic [ght_pkg::ADDR_W-1:0]    csr_paddr,
   input  wire logic [ght_pkg::BOOT_W-1:0]    csr_pwdata,
   output logic      [ght_pkg::BOOT_W-1:0]    csr_prdata,
   output logic                               csr_pready
);
   import ght_pkg::*;

   logic [BOOT_W-1:0] boot_ff, boot_in;
   logic              cfg_sel, cfg_wr;
   cell_ctrl_type     cell_ctrl;
   ctrl_status_type   ctrl_status;
   slot_type          cell_q [SLOTS];
   logic [SLOTS-1:0]  cell_wr;

   assign csr_pready = 1'b1;
   assign cfg_sel    = (csr_paddr[ADDR_W-1:REG_LSB] == REG_BOOT);
   assign cfg_wr     = csr_psel && csr_penable && csr_pwrite && cfg_sel;
   assign csr_prdata = cfg_sel ? boot_ff : '0;
   assign boot_in    = cfg_wr ? csr_pwdata : boot_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         boot_ff <= '0;
      end else begin
         boot_ff <= boot_in;
      end
   end

   ght_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .rsp_bus    (rsp_bus),
      .boot       (boot_ff),
      .cfg_wr     (cfg_wr),
      .head       (cell_q[0]),
      .cell_ctrl  (cell_ctrl),
      .status_out (ctrl_status)
   );

   for (genvar k = 0; k < SLOTS; k++) begin : g_cell
      assign cell_wr[k] = cell_ctrl.wr_en && (cell_ctrl.wr_index == IDX_W'(k));

      ght_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .shift     (cell_ctrl.shift),
         .clear     (cfg_wr),
         .wr_sel    (cell_wr[k]),
         .wr_slot   (cell_ctrl.wr_slot),
         .from_next (cell_q[(k + 1) % SLOTS]),
         .q         (cell_q[k])
      );
   end

   `GHT_ASSERT_NOW(a_single_fill, clock, reset, 1'b1, $onehot0(cell_wr))
   `GHT_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_bus.valid && req_bus.ready, ctrl_status.busy)
   `GHT_ASSERT_NEXT(a_cfg_empties, clock, reset, cfg_wr, ctrl_status.used == '0)
   `GHT_ASSERT_NOW(a_used_bound, clock, reset, 1'b1, ctrl_status.used <= CNT_W'(SLOTS))

endmodule

`default_nettype wire
